[hdl/double_word_unsigned_divider_core_defines.svh]
// Assertion macros shared by the divider checker.
`ifndef DOUBLE_WORD_UNSIGNED_DIVIDER_CORE_DEFINES_SVH
`define DOUBLE_WORD_UNSIGNED_DIVIDER_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define DWDIV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that a condition never holds outside reset.
`define DWDIV_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/dwdiv_pkg.sv]
`default_nettype none

package dwdiv_pkg;

	// Width of the divisor, the quotient and each dividend half.
	localparam int WORD_BITS = 64;

	// One division round per cell, so the chain is this long.
	localparam int ROUNDS = WORD_BITS;

	// Everything one cell hands to its right-hand neighbor.
	typedef struct packed {
		logic                 valid;
		logic                 dbz;
		logic [WORD_BITS-1:0] rem;
		logic [WORD_BITS-1:0] src;
		logic [WORD_BITS-1:0] quo;
		logic [WORD_BITS-1:0] dv;
	} stage_t;

endpackage

`default_nettype wire

[hdl/double_word_unsigned_divider_core.sv]
// Channel  | Ports                                          | Marked by
// ---------+------------------------------------------------+-------------------
// Input    | dividend_high, dividend_low, divisor_value     | start high, busy low
// Result   | quotient_value, divide_by_zero                 | done, one cycle
//
// One word is accepted in every cycle; busy stays low since the chain never stalls.
// Each word is registered once in every one of the 64 shift-subtract cells of
// the chain, one cell per quotient bit, before its result appears.
// Reset clears only the valid bits of the chain; words in flight are dropped.
// The receiver cannot stall: done is high for exactly one cycle per word.

`default_nettype none

module double_word_unsigned_divider_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [dwdiv_pkg::WORD_BITS-1:0]      dividend_high,
	input  wire  [dwdiv_pkg::WORD_BITS-1:0]      dividend_low,
	input  wire  [dwdiv_pkg::WORD_BITS-1:0]      divisor_value,
	output logic                                 done,
	output logic [dwdiv_pkg::WORD_BITS-1:0]      quotient_value,
	output logic                                 divide_by_zero
);

	dwdiv_pkg::stage_t chain [0:dwdiv_pkg::ROUNDS];

	// The chain always moves, so new words are never held off.
	assign busy = 1'b0;

	// Entry of the chain: the high word is the starting remainder.
	assign chain[0].valid = start;
	assign chain[0].dbz   = (divisor_value == '0);
	assign chain[0].rem   = dividend_high;
	assign chain[0].src   = dividend_low;
	assign chain[0].quo   = '0;
	assign chain[0].dv    = divisor_value;

	// One cell per quotient bit.
	for (genvar i = 0; i < dwdiv_pkg::ROUNDS; i++) begin : g_cell
		dwdiv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cur    (chain[i]),
			.nxt    (chain[i+1])
		);
	end

	// A zero divisor forces the quotient to zero.
	always_comb begin
		done           = chain[dwdiv_pkg::ROUNDS].valid;
		divide_by_zero = chain[dwdiv_pkg::ROUNDS].dbz;
		quotient_value = chain[dwdiv_pkg::ROUNDS].dbz ? '0 : chain[dwdiv_pkg::ROUNDS].quo;
	end

endmodule

`default_nettype wire

[hdl/dwdiv_cell.sv]
`default_nettype none

module dwdiv_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  dwdiv_pkg::stage_t       cur,
	output dwdiv_pkg::stage_t       nxt
);

	logic [dwdiv_pkg::WORD_BITS-1:0] rem_sh;
	logic [dwdiv_pkg::WORD_BITS-1:0] diff;
	logic                            borrow;
	logic                            take;
	logic                            valid_q;
	logic                            dbz_q;
	logic [dwdiv_pkg::WORD_BITS-1:0] rem_q;
	logic [dwdiv_pkg::WORD_BITS-1:0] src_q;
	logic [dwdiv_pkg::WORD_BITS-1:0] quo_q;
	logic [dwdiv_pkg::WORD_BITS-1:0] dv_q;

	// Shift the next dividend bit in and try the subtraction.
	always_comb begin
		rem_sh         = {cur.rem[dwdiv_pkg::WORD_BITS-2:0], cur.src[dwdiv_pkg::WORD_BITS-1]};
		{borrow, diff} = {1'b0, rem_sh} - {1'b0, cur.dv};
		// Subtract when a set bit fell off the top or the remainder is large enough.
		take           = cur.rem[dwdiv_pkg::WORD_BITS-1] | ~borrow;
	end

	// The valid bit is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cur.valid;
		end
	end

	// Payload moves on every cycle without reset.
	always_ff @(posedge clk) begin
		dbz_q <= cur.dbz;
		dv_q  <= cur.dv;
		src_q <= {cur.src[dwdiv_pkg::WORD_BITS-2:0], 1'b0};
		quo_q <= {cur.quo[dwdiv_pkg::WORD_BITS-2:0], take};
		rem_q <= take ? diff : rem_sh;
	end

	// Hand the registered word to the next cell.
	always_comb begin
		nxt.valid = valid_q;
		nxt.dbz   = dbz_q;
		nxt.rem   = rem_q;
		nxt.src   = src_q;
		nxt.quo   = quo_q;
		nxt.dv    = dv_q;
	end

endmodule

`default_nettype wire

[hdl/dwdiv_checker.sv]
`default_nettype none

`include "double_word_unsigned_divider_core_defines.svh"

module dwdiv_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             start,
	input wire                             busy,
	input wire [dwdiv_pkg::WORD_BITS-1:0]  divisor_value,
	input wire                             done,
	input wire [dwdiv_pkg::WORD_BITS-1:0]  quotient_value,
	input wire                             divide_by_zero
);

	// The chain never refuses a word.
	`DWDIV_NEVER(a_never_busy, busy, "busy raised although the chain never stalls")

	// Every accepted word comes out after the full chain.
	`DWDIV_ASSERT(a_done_after_chain, (start && !busy) |-> ##(dwdiv_pkg::ROUNDS) done, "accepted word did not come out after the chain")

	// A zero divisor is flagged on its own result.
	`DWDIV_ASSERT(a_zero_flagged, (start && !busy && divisor_value == '0) |-> ##(dwdiv_pkg::ROUNDS) (done && divide_by_zero), "zero divisor not flagged")

	// A flagged result carries a zero quotient.
	`DWDIV_ASSERT(a_zero_quotient, (done && divide_by_zero) |-> (quotient_value == '0), "quotient not zero on divide by zero")

endmodule

bind double_word_unsigned_divider_core dwdiv_checker u_dwdiv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.divisor_value  (divisor_value),
	.done           (done),
	.quotient_value (quotient_value),
	.divide_by_zero (divide_by_zero)
);

`default_nettype wire

[bench/double_word_unsigned_divider_core_tb.sv]
`timescale 1ns / 1ps

module double_word_unsigned_divider_core_tb;

	localparam int W = dwdiv_pkg::WORD_BITS;
	// The chain is one cell per quotient bit, and results come out after passing through every cell.
	localparam int CHAIN_CYCLES = dwdiv_pkg::ROUNDS;
	localparam int REPORT_LIMIT = 10;

	// One quotient as the block should return it.
	typedef struct {
		logic [W-1:0] quo;
		logic         dbz;
	} quotient_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic [W-1:0] dividend_high = '0;
	logic [W-1:0] dividend_low = '0;
	logic [W-1:0] divisor_value = '0;
	wire          busy;
	wire          done;
	wire  [W-1:0] quotient_value;
	wire          divide_by_zero;

	quotient_t pending_quotients[$];
	quotient_t oldest;
	int        error_count = 0;
	int        words_sent = 0;
	int        quotients_seen = 0;
	int        zero_divisor_words = 0;
	int        overflow_words = 0;

	double_word_unsigned_divider_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.dividend_high  (dividend_high),
		.dividend_low   (dividend_low),
		.divisor_value  (divisor_value),
		.done           (done),
		.quotient_value (quotient_value),
		.divide_by_zero (divide_by_zero)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Restoring shift-subtract division, one quotient bit per round.
	// A bit carried out of the remainder forces the subtraction, which is
	// what gives the wrapped quotient when the high word is not below the divisor.
	function automatic quotient_t divide_restoring(logic [W-1:0] hi, logic [W-1:0] lo,
			logic [W-1:0] dv);
		quotient_t    res;
		logic [W-1:0] rem;
		logic [W-1:0] src;
		logic         carry;
		res.quo = '0;
		res.dbz = 1'b0;
		if (dv == '0) begin
			res.dbz = 1'b1;
			return res;
		end
		rem = hi;
		src = lo;
		for (int r = 0; r < W; r++) begin
			carry = rem[W-1];
			rem = {rem[W-2:0], src[W-1]};
			src = src << 1;
			res.quo = res.quo << 1;
			if (carry || rem >= dv) begin
				rem = rem - dv;
				res.quo[0] = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic [W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Present one word and hold it until the block takes it. Start is left high
	// so that a following word goes out on the very next cycle.
	task automatic send_word(input logic [W-1:0] hi, input logic [W-1:0] lo,
			input logic [W-1:0] dv);
		start <= 1'b1;
		dividend_high <= hi;
		dividend_low <= lo;
		divisor_value <= dv;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_quotients.push_back(divide_restoring(hi, lo, dv));
		words_sent++;
		if (dv == '0)
			zero_divisor_words++;
		else if (hi >= dv)
			overflow_words++;
	endtask

	// Drop start for an idle burst of random length, with junk on the operand ports meanwhile.
	task automatic idle_burst();
		int n;
		n = $urandom_range(1, 3);
		start <= 1'b0;
		dividend_high <= rand_word();
		dividend_low <= rand_word();
		divisor_value <= rand_word();
		repeat (n) @(posedge clk);
	endtask

	// Random operands shaped so that most divisions stay in range: divisors of
	// every length, high word mostly below the divisor, a few zero divisors.
	task automatic send_random_word(input bit allow_idle);
		logic [W-1:0] hi;
		logic [W-1:0] dv;
		int           sel;
		if (allow_idle && $urandom_range(0, 3) == 0)
			idle_burst();
		sel = $urandom_range(0, 19);
		dv = rand_word() >> $urandom_range(0, W - 1);
		if (sel == 0)
			dv = '0;
		if (sel <= 3 || dv == '0)
			hi = rand_word() >> $urandom_range(0, W - 1);
		else
			hi = rand_word() % dv;
		send_word(hi, rand_word(), dv);
	endtask

	// Edge values of all three operands, all but one in range.
	task automatic test_extremes();
		send_word('0, '0, 64'd1);
		send_word('0, '1, 64'd1);
		send_word('0, '1, '1);
		send_word('1 - 64'd1, '1, '1);
		send_word('1 - 64'd1, '0, '1);
		send_word(64'h7fff_ffff_ffff_ffff, '1, 64'h8000_0000_0000_0000);
		send_word('0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		send_word(64'd2, 64'd7, 64'd3);
		send_word(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h1_0000_0000);
		idle_burst();
		send_word(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, '1);
	endtask

	// A zero divisor flags an error and gives a zero quotient, whatever the dividend.
	task automatic test_zero_divisor();
		send_word('0, '0, '0);
		send_word('1, '1, '0);
		send_word(64'd1, 64'd1, '0);
		idle_burst();
		send_word(64'h8000_0000_0000_0000, 64'h5a5a_5a5a_5a5a_5a5a, '0);
	endtask

	// High word at or above the divisor: no flag, the quotient simply wraps.
	task automatic test_high_word_overflow();
		send_word(64'd5, '0, 64'd3);
		send_word(64'd3, '1, 64'd3);
		send_word('1, '1, 64'd1);
		send_word('1, '0, '1);
		send_word('1, '1, '1);
		send_word(64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0000);
		send_word('1, 64'h1234_5678_9abc_def0, 64'h8000_0000_0000_0001);
		send_word(64'hffff_0000_ffff_0000, 64'h0f0f_0f0f_0f0f_0f0f, 64'd7);
	endtask

	// Random words with idle bursts between some of them.
	task automatic test_random_words();
		repeat (720) send_random_word(1'b1);
	endtask

	// Closing stretch with a new word on every cycle.
	task automatic test_back_to_back();
		repeat (160) send_random_word(1'b0);
	endtask

	// Each strobed quotient must match the oldest word still in flight.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			quotients_seen++;
			if (pending_quotients.size() == 0) begin
				note_error($sformatf("quotient %h with no word in flight", quotient_value));
			end else begin
				oldest = pending_quotients.pop_front();
				if (quotient_value !== oldest.quo)
					note_error($sformatf("quotient_value expected %h actual %h",
						oldest.quo, quotient_value));
				if (divide_by_zero !== oldest.dbz)
					note_error($sformatf("divide_by_zero expected %b actual %b",
						oldest.dbz, divide_by_zero));
			end
		end
	end

	// Watchdog for a block that stops answering.
	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_zero_divisor();
		test_high_word_overflow();
		test_random_words();
		test_back_to_back();
		start <= 1'b0;

		// Let the chain empty, then watch a while longer for stray strobes.
		waited = 0;
		while (pending_quotients.size() != 0 && waited < 4 * CHAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (pending_quotients.size() != 0)
			note_error($sformatf("%0d quotients never arrived", pending_quotients.size()));
		repeat (CHAIN_CYCLES + 8) @(posedge clk);

		$display("Sent %0d words (%0d zero divisors, %0d with high word >= divisor),",
			words_sent, zero_divisor_words, overflow_words);
		$display("checked %0d quotients; %0d mismatches in total.", quotients_seen, error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
